// ===== rtl/i2t_pkg.sv =====
// ----------------------------------------------------------------------------
// i2t_pkg: shared types and constants of the i2t overload integrator
// Field widths, register reset values, register indexes, controller states
// and the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package i2t_pkg;

  // Default values of the top-level parameters.
  localparam int CURRENT_BITS_DEF = 16;
  localparam int ACC_BITS_DEF     = 48;

  // Fixed widths of the channel fields and registers.
  localparam int LOAD_W      = 16;
  localparam int ACC_OUT_W   = 48;
  localparam int LIMIT_W     = 48;
  localparam int PCT_W       = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 48;
  localparam int DIV_CNT_W   = $clog2(PCT_W);

  // Largest load percentage that can be reported.
  localparam logic [PCT_W-1:0] PCT_MAX = {PCT_W{1'b1}};

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_MODE       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_CURRENT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_CURRENT     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATOR_LIMIT = 8'd3;

  // Register values after reset.
  localparam logic                 RST_LINEAR_MODE       = 1'b0;
  localparam logic [LOAD_W-1:0]    RST_NOMINAL_CURRENT   = 16'd1000;
  localparam logic [LOAD_W-1:0]    RST_UPPER_CURRENT     = 16'd1020;
  localparam logic [LIMIT_W-1:0]   RST_ACCUMULATOR_LIMIT = 48'd60000;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic               linear_mode;
    logic [LOAD_W-1:0]  nominal_current;
    logic [LOAD_W-1:0]  upper_current;
    logic [LIMIT_W-1:0] accumulator_limit;
  } i2t_cfg_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_CUR,
    S_SQ_NOM,
    S_UPD,
    S_SCALE,
    S_CHECK,
    S_DIV,
    S_RES
  } i2t_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic load_csq;
    logic load_nsq;
    logic upd_acc;
    logic load_scaled;
    logic div_init;
    logic div_step;
    logic load_out;
  } i2t_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pct_sat;
  } i2t_sts_t;

endpackage

`default_nettype wire

// ===== rtl/i2t_ifs.sv =====
// ----------------------------------------------------------------------------
// i2t channel interfaces
// Valid/ready channels for the sample input, the result output and the
// register write port. A word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2t_in_if;
  logic                      valid;
  logic                      ready;
  logic [i2t_pkg::LOAD_W-1:0] load_current;

  modport source (output valid, output load_current, input ready);
  modport sink   (input valid, input load_current, output ready);
endinterface

interface i2t_out_if;
  logic                         valid;
  logic                         ready;
  logic [i2t_pkg::ACC_OUT_W-1:0] accumulator_value;
  logic                         overload;
  logic [i2t_pkg::PCT_W-1:0]     load_percent;

  modport source (output valid, output accumulator_value, output overload,
                  output load_percent, input ready);
  modport sink   (input valid, input accumulator_value, input overload,
                  input load_percent, output ready);
endinterface

interface i2t_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [i2t_pkg::CFG_IDX_W-1:0]  index;
  logic [i2t_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2t_cfg.sv =====
// ----------------------------------------------------------------------------
// i2t_cfg: configuration registers
// Takes register writes from the configuration port; unknown indexes are
// ignored. Always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module i2t_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  i2t_cfg_if.sink          cfg_ch,
  output i2t_pkg::i2t_cfg_t cfg
);

  i2t_pkg::i2t_cfg_t regs_r;
  logic              wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;
  assign cfg          = regs_r;

  // Register file, each write trimmed to the register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.linear_mode       <= i2t_pkg::RST_LINEAR_MODE;
      regs_r.nominal_current   <= i2t_pkg::RST_NOMINAL_CURRENT;
      regs_r.upper_current     <= i2t_pkg::RST_UPPER_CURRENT;
      regs_r.accumulator_limit <= i2t_pkg::RST_ACCUMULATOR_LIMIT;
    end else if (wr_en) begin
      unique case (cfg_ch.index)
        i2t_pkg::CFG_LINEAR_MODE: begin
          regs_r.linear_mode <= cfg_ch.data[0];
        end
        i2t_pkg::CFG_NOMINAL_CURRENT: begin
          regs_r.nominal_current <= cfg_ch.data[i2t_pkg::LOAD_W-1:0];
        end
        i2t_pkg::CFG_UPPER_CURRENT: begin
          regs_r.upper_current <= cfg_ch.data[i2t_pkg::LOAD_W-1:0];
        end
        i2t_pkg::CFG_ACCUMULATOR_LIMIT: begin
          regs_r.accumulator_limit <= cfg_ch.data[i2t_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2t_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2t_ctrl: sequencing controller
// Walks one sample through squaring, accumulator update, scaling and the
// percentage division unless it saturates, then loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2t_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output i2t_pkg::i2t_cmd_t      cmd,
  input  wire i2t_pkg::i2t_sts_t sts
);

  localparam int CNT_W = i2t_pkg::DIV_CNT_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(i2t_pkg::PCT_W - 1);

  i2t_pkg::i2t_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  // State, division step counter and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2t_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = '0;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      i2t_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = i2t_pkg::S_SQ_CUR;
        end
      end
      i2t_pkg::S_SQ_CUR: begin
        cmd.load_csq = 1'b1;
        state_nxt    = i2t_pkg::S_SQ_NOM;
      end
      i2t_pkg::S_SQ_NOM: begin
        cmd.load_nsq = 1'b1;
        state_nxt    = i2t_pkg::S_UPD;
      end
      i2t_pkg::S_UPD: begin
        cmd.upd_acc = 1'b1;
        state_nxt   = i2t_pkg::S_SCALE;
      end
      i2t_pkg::S_SCALE: begin
        cmd.load_scaled = 1'b1;
        state_nxt       = i2t_pkg::S_CHECK;
      end
      i2t_pkg::S_CHECK: begin
        cmd.div_init = 1'b1;
        state_nxt    = sts.pct_sat ? i2t_pkg::S_RES : i2t_pkg::S_DIV;
      end
      i2t_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = i2t_pkg::S_RES;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      i2t_pkg::S_RES: begin
        // Load the output register once the previous word has left.
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = i2t_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = i2t_pkg::S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // An accepted sample always starts the squaring step.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == i2t_pkg::S_SQ_CUR))
    else $error("sample accepted but squaring did not start");

  // The division always begins at its first step.
  a_div_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == i2t_pkg::S_CHECK && !sts.pct_sat)
      |=> (state_r == i2t_pkg::S_DIV && cnt_r == '0))
    else $error("division entered with a stale step count");

  // The step counter is idle outside the division.
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != i2t_pkg::S_DIV) |-> (cnt_r == '0))
    else $error("step counter running outside the division");
`endif

endmodule

`default_nettype wire

// ===== rtl/i2t_dp.sv =====
// ----------------------------------------------------------------------------
// i2t_dp: accumulator and percentage datapath
// One shared squarer, the saturating accumulator, the times-100 scaler and
// a one-bit-per-cycle restoring divider for the load percentage.
// ----------------------------------------------------------------------------
`default_nettype none

module i2t_dp #(
  parameter int CURRENT_BITS = i2t_pkg::CURRENT_BITS_DEF,
  parameter int ACC_BITS     = i2t_pkg::ACC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire i2t_pkg::i2t_cmd_t             cmd,
  input  wire i2t_pkg::i2t_cfg_t             cfg,
  input  wire logic [i2t_pkg::LOAD_W-1:0]    load_current,
  output i2t_pkg::i2t_sts_t                  sts,
  output logic [i2t_pkg::ACC_OUT_W-1:0]      accumulator_value,
  output logic                               overload,
  output logic [i2t_pkg::PCT_W-1:0]          load_percent
);

  localparam int LW  = i2t_pkg::LIMIT_W;
  localparam int QW  = i2t_pkg::PCT_W;
  // Effective current width: the sample is masked to CURRENT_BITS.
  localparam int EW  = (CURRENT_BITS < i2t_pkg::LOAD_W) ? CURRENT_BITS : i2t_pkg::LOAD_W;
  localparam int PW  = 2 * EW;
  localparam int AW  = ACC_BITS;
  localparam int SW  = ((AW > PW) ? AW : PW) + 1;
  localparam int CW  = (AW > LW) ? AW : LW;
  // The accumulator times 100 needs seven more bits.
  localparam int NW  = AW + 7;
  localparam int HW  = ((NW - QW) > LW) ? (NW - QW) : LW;

  logic [EW-1:0] cur_r;
  logic [PW-1:0] csq_r, nsq_r;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [NW-1:0] n_r;
  logic [LW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] nlo_r, quo_r;
  logic          sat_r;
  logic [i2t_pkg::ACC_OUT_W-1:0] acc_out_r;
  logic          ovl_r;
  logic [QW-1:0] pct_r;

  logic [EW-1:0] nom, up, mul_op;
  logic [PW-1:0] prod, mag;
  logic          above, below, grow, do_add, do_sub;
  logic [SW-1:0] amt, sum, acc_ext;
  logic [AW-1:0] acc_add_val, acc_sub_val;
  logic [NW-1:0] scaled;
  logic [HW-1:0] n_hi;
  logic          pct_sat;
  logic [LW:0]   rem_sh, lim_ext;
  logic [LW-1:0] rem_dif;
  logic          qbit;

  assign nom = cfg.nominal_current[EW-1:0];
  assign up  = cfg.upper_current[EW-1:0];

  // Shared squarer: current first, nominal current in the next cycle.
  assign mul_op = cmd.load_nsq ? nom : cur_r;
  assign prod   = PW'(mul_op) * PW'(mul_op);

  // Threshold tests and the size of the squared step.
  assign above = cur_r > up;
  assign below = cur_r < nom;
  assign grow  = csq_r >= nsq_r;
  assign mag   = grow ? (csq_r - nsq_r) : (nsq_r - csq_r);

  // Direction and amount of the accumulator change.
  always_comb begin
    if (cfg.linear_mode) begin
      do_add = above;
      do_sub = !above && below;
      amt    = SW'(1);
    end else begin
      do_add = (above || below) && grow;
      do_sub = (above || below) && !grow;
      amt    = SW'(mag);
    end
  end

  // Saturating add and floored subtract.
  assign acc_ext     = SW'(acc_r);
  assign sum         = acc_ext + amt;
  assign acc_add_val = (sum > SW'({AW{1'b1}})) ? {AW{1'b1}} : sum[AW-1:0];
  assign acc_sub_val = (amt >= acc_ext) ? '0 : AW'(acc_ext - amt);

  always_comb begin
    if (do_add) begin
      acc_nxt = acc_add_val;
    end else if (do_sub) begin
      acc_nxt = acc_sub_val;
    end else begin
      acc_nxt = acc_r;
    end
  end

  // Accumulator times 100 as shifted adds (64 + 32 + 4).
  assign scaled = (NW'(acc_r) << 6) + (NW'(acc_r) << 5) + (NW'(acc_r) << 2);

  // The quotient overflows 16 bits when the high part reaches the limit.
  assign n_hi    = HW'(n_r >> QW);
  assign pct_sat = (cfg.accumulator_limit == '0) || (n_hi >= HW'(cfg.accumulator_limit));
  assign sts.pct_sat = pct_sat;

  // One restoring division step: bring down a bit, subtract if it fits.
  // The difference is below the limit whenever it is taken.
  assign rem_sh  = {rem_r, nlo_r[QW-1]};
  assign lim_ext = {1'b0, cfg.accumulator_limit};
  assign qbit    = rem_sh >= lim_ext;
  assign rem_dif = LW'(rem_sh - lim_ext);
  assign rem_nxt = qbit ? rem_dif : rem_sh[LW-1:0];

  // Accumulator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.upd_acc) begin
      acc_r <= acc_nxt;
    end
  end

  // Working registers of the sequence.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_r <= load_current[EW-1:0];
    end
    if (cmd.load_csq) begin
      csq_r <= prod;
    end
    if (cmd.load_nsq) begin
      nsq_r <= prod;
    end
    if (cmd.load_scaled) begin
      n_r <= scaled;
    end
    if (cmd.div_init) begin
      rem_r <= LW'(n_hi);
      nlo_r <= n_r[QW-1:0];
      quo_r <= '0;
      sat_r <= pct_sat;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      nlo_r <= {nlo_r[QW-2:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], qbit};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      acc_out_r <= i2t_pkg::ACC_OUT_W'(acc_r);
      ovl_r     <= CW'(acc_r) > CW'(cfg.accumulator_limit);
      pct_r     <= sat_r ? i2t_pkg::PCT_MAX : quo_r;
    end
  end

  assign accumulator_value = acc_out_r;
  assign overload          = ovl_r;
  assign load_percent      = pct_r;

`ifndef ASSERT_OFF
  // In linear mode one sample moves the accumulator by at most one.
  a_linear_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd_acc && cfg.linear_mode)
      |=> (acc_r == $past(acc_r) || acc_r == $past(acc_r) + AW'(1)
           || acc_r == $past(acc_r) - AW'(1)))
    else $error("linear mode moved the accumulator by more than one");

  // The partial remainder stays below the divisor throughout the division.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < cfg.accumulator_limit))
    else $error("division remainder reached the limit");
`endif

endmodule

`default_nettype wire

// ===== rtl/i2t_overload_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// i2t_overload_integrator_unit: current-time overload integrator
// Integrates load-current samples into an overload accumulator and reports
// the accumulator, the overload flag and the load percentage for each one.
// ----------------------------------------------------------------------------
// Each sample word on the input channel yields exactly one result word. The
// block works on one sample at a time: after acceptance the sample runs
// through the squaring, update, scaling, check and division states to the
// result state, which loads the output register, and a new sample is taken
// in the idle state after it. When the percentage saturates or the limit is
// zero the division is skipped. The restoring divider produces one
// percentage bit per cycle. A finished result waits in the output register
// while the next sample is already accepted; a stalled output holds the
// block only when the following result is ready to load. Register writes
// are taken at any time and always accepted, but should be made only while
// no sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module i2t_overload_integrator_unit #(
  parameter int CURRENT_BITS = i2t_pkg::CURRENT_BITS_DEF,
  parameter int ACC_BITS     = i2t_pkg::ACC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  i2t_in_if.sink    in_ch,
  i2t_out_if.source out_ch,
  i2t_cfg_if.sink   cfg_ch
);

  i2t_pkg::i2t_cfg_t cfg;
  i2t_pkg::i2t_cmd_t cmd;
  i2t_pkg::i2t_sts_t sts;
  logic              in_ready;
  logic              out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // Configuration registers.
  i2t_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Sequencing controller.
  i2t_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Accumulator and percentage datapath.
  i2t_dp #(
    .CURRENT_BITS (CURRENT_BITS),
    .ACC_BITS     (ACC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg               (cfg),
    .load_current      (in_ch.load_current),
    .sts               (sts),
    .accumulator_value (out_ch.accumulator_value),
    .overload          (out_ch.overload),
    .load_percent      (out_ch.load_percent)
  );

endmodule

`default_nettype wire

// ===== tb/i2t_overload_integrator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// i2t_overload_integrator_unit_tb: self-checking testbench
// Drives load-current samples through the valid/ready input channel. A
// predictor tracks the accumulator, thresholds and limit and queues the
// expected result word for each accepted sample. The results that come back
// are compared field by field. Directed tests cover the threshold edges,
// both modes, the limit extremes and unknown register indexes. Random bursts
// run under several register settings, with idle and stall patterns on both
// channels and a long output stall.
// ----------------------------------------------------------------------------
module i2t_overload_integrator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2t_pkg::*;

  localparam logic [ACC_OUT_W-1:0] ACC_FULL      = {ACC_OUT_W{1'b1}};
  localparam int unsigned          CUR_TOP       = 2 ** LOAD_W - 1;
  localparam int unsigned          SETTLE_CYCLES = 30;
  localparam int unsigned          CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned          SEGMENT_WORDS = 225;
  localparam int unsigned          SEGMENTS      = 8;
  localparam int unsigned          HOLD_CYCLES   = 300;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW = CFG_ACCUMULATOR_LIMIT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic [ACC_OUT_W-1:0] accumulator_value;
    logic                 overload;
    logic [PCT_W-1:0]     load_percent;
  } i2t_result_t;

  // Classes of sample current relative to the thresholds.
  typedef enum logic [2:0] {
    CUR_ABOVE,
    CUR_BELOW,
    CUR_BAND,
    CUR_EDGE,
    CUR_ANY
  } current_class_e;

  logic clk;
  logic rst_n;

  i2t_in_if  in_ch ();
  i2t_out_if out_ch ();
  i2t_cfg_if cfg_ch ();

  i2t_overload_integrator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor copy of the registers and the accumulator.
  logic                 mdl_linear;
  logic [LOAD_W-1:0]    mdl_nominal;
  logic [LOAD_W-1:0]    mdl_upper;
  logic [LIMIT_W-1:0]   mdl_limit;
  logic [ACC_OUT_W-1:0] mdl_acc;

  i2t_result_t pending_results[$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_orders    = 0;
  int unsigned hold_span      = 0;
  int unsigned fail_count     = 0;
  int unsigned samples_sent   = 0;
  int unsigned reg_writes     = 0;
  int unsigned cycle_count    = 0;

  // Clock generation.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles with %0d results pending", cycle_count,
             pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Load percentage, floored and saturated; a zero limit reads as full scale.
  function automatic logic [PCT_W-1:0] percent_of_limit(logic [63:0] acc, logic [63:0] lim);
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] pct;
    if (lim == 64'd0) return PCT_MAX;
    quo = acc / lim;
    rem = acc % lim;
    if (quo > 64'(PCT_MAX) / 64'd100) return PCT_MAX;
    pct = quo * 64'd100 + (rem * 64'd100) / lim;
    return (pct > 64'(PCT_MAX)) ? PCT_MAX : pct[PCT_W-1:0];
  endfunction

  // Integrate one sample into the accumulator and form its result word.
  function automatic i2t_result_t integrate_sample(logic [LOAD_W-1:0] cur);
    logic [63:0] acc;
    logic [63:0] cur_sq;
    logic [63:0] nom_sq;
    logic [63:0] delta;
    i2t_result_t res;
    acc = 64'(mdl_acc);
    if (mdl_linear) begin
      // The upper threshold wins when it lies below nominal.
      if (cur > mdl_upper) begin
        acc = (acc == 64'(ACC_FULL)) ? acc : acc + 64'd1;
      end else if (cur < mdl_nominal) begin
        acc = (acc == 64'd0) ? acc : acc - 64'd1;
      end
    end else if (cur > mdl_upper || cur < mdl_nominal) begin
      cur_sq = 64'(cur) * 64'(cur);
      nom_sq = 64'(mdl_nominal) * 64'(mdl_nominal);
      if (cur_sq >= nom_sq) begin
        delta = cur_sq - nom_sq;
        acc = (delta > 64'(ACC_FULL) - acc) ? 64'(ACC_FULL) : acc + delta;
      end else begin
        delta = nom_sq - cur_sq;
        acc = (delta >= acc) ? 64'd0 : acc - delta;
      end
    end
    mdl_acc = acc[ACC_OUT_W-1:0];
    res.accumulator_value = mdl_acc;
    res.overload          = (mdl_acc > mdl_limit);
    res.load_percent      = percent_of_limit(acc, 64'(mdl_limit));
    return res;
  endfunction

  // Pick a sample current of the given class under the present thresholds.
  function automatic logic [LOAD_W-1:0] pick_current(current_class_e cls);
    int unsigned lo;
    int unsigned hi;
    int unsigned nom;
    int unsigned up;
    nom = mdl_nominal;
    up  = mdl_upper;
    lo  = 0;
    hi  = CUR_TOP;
    case (cls)
      CUR_ABOVE: begin
        if (up == CUR_TOP) return mdl_upper;
        lo = up + 1;
        if ($urandom_range(1) == 1) hi = (up + 1 + up / 4 < CUR_TOP) ? up + 1 + up / 4 : CUR_TOP;
      end
      CUR_BELOW: begin
        if (nom == 0) return '0;
        hi = nom - 1;
        if ($urandom_range(1) == 1) lo = nom - 1 - (nom - 1) / 8;
      end
      CUR_BAND: begin
        lo = (nom < up) ? nom : up;
        hi = (nom < up) ? up : nom;
      end
      CUR_EDGE: begin
        case ($urandom_range(5))
          0: return '0;
          1: return '1;
          2: return mdl_nominal;
          3: return mdl_upper;
          4: return mdl_nominal - 1'b1;
          default: return mdl_upper + 1'b1;
        endcase
      end
      default: ;
    endcase
    return LOAD_W'($urandom_range(hi, lo));
  endfunction

  // Offer one sample word, with random idle cycles ahead of it.
  task automatic send_sample(input logic [LOAD_W-1:0] cur);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.load_current <= cur;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(integrate_sample(cur));
    samples_sent++;
  endtask

  // Stop sending and wait until every expected result word has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; valid stays high so writes can follow back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_LINEAR_MODE:       mdl_linear  = val[0];
      CFG_NOMINAL_CURRENT:   mdl_nominal = val[LOAD_W-1:0];
      CFG_UPPER_CURRENT:     mdl_upper   = val[LOAD_W-1:0];
      CFG_ACCUMULATOR_LIMIT: mdl_limit   = val[LIMIT_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Program all four registers once the block is idle. Unused data bits
  // carry random noise that the block must drop.
  task automatic configure(input logic lin, input logic [LOAD_W-1:0] nom,
                           input logic [LOAD_W-1:0] up, input logic [LIMIT_W-1:0] lim,
                           input bit with_unknown);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'({$urandom(), $urandom()});
    drain_results();
    if (with_unknown) begin
      write_reg(CFG_UNUSED_LOW, '1);
      write_reg(CFG_UNUSED_TOP, noise);
    end
    write_reg(CFG_LINEAR_MODE, {noise[CFG_DATA_W-1:1], lin});
    write_reg(CFG_NOMINAL_CURRENT, {noise[CFG_DATA_W-1:LOAD_W], nom});
    write_reg(CFG_UPPER_CURRENT, {noise[CFG_DATA_W-1:LOAD_W], up});
    write_reg(CFG_ACCUMULATOR_LIMIT, CFG_DATA_W'(lim));
    cfg_ch.valid <= 1'b0;
  endtask

  // Random register setting, with the extremes among the choices.
  task automatic apply_random_setting();
    logic               lin;
    logic [LOAD_W-1:0]  nom;
    logic [LOAD_W-1:0]  up;
    logic [LIMIT_W-1:0] lim;
    logic [31:0]        up_wide;
    logic [63:0]        unit_step;
    lin = 1'($urandom_range(1));
    case ($urandom_range(4))
      0: nom = LOAD_W'($urandom_range(200));
      1: nom = '1;
      2: nom = LOAD_W'($urandom());
      default: nom = LOAD_W'($urandom_range(5000, 500));
    endcase
    up_wide = 32'(nom) + 32'(nom) / 50 + 32'd1;
    case ($urandom_range(9))
      0: up = LOAD_W'($urandom());
      1: up = nom - LOAD_W'($urandom_range(50));
      default: up = (up_wide > CUR_TOP) ? '1 : LOAD_W'(up_wide);
    endcase
    unit_step = lin ? 64'd1 : 64'(nom) * 64'(nom) / 64'd8 + 64'd1;
    case ($urandom_range(9))
      0: lim = '0;
      1: lim = '1;
      2: lim = LIMIT_W'(1);
      default: lim = LIMIT_W'(unit_step * 64'($urandom_range(60, 1)));
    endcase
    configure(lin, nom, up, lim, 1'b0);
  endtask

  // Bursts of overload and recovery with some noise in between.
  task automatic run_traffic(input int unsigned words);
    int unsigned    left;
    int unsigned    run;
    int unsigned    pick;
    current_class_e cls;
    left = words;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 40) cls = CUR_ABOVE;
      else if (pick < 70) cls = CUR_BELOW;
      else if (pick < 80) cls = CUR_BAND;
      else if (pick < 90) cls = CUR_EDGE;
      else cls = CUR_ANY;
      run = (cls == CUR_EDGE || cls == CUR_ANY) ? $urandom_range(4, 1) : $urandom_range(30, 3);
      if (run > left) run = left;
      repeat (run) send_sample(pick_current(cls));
      left -= run;
    end
  endtask

  // Threshold edges under the register values after reset.
  task automatic test_reset_defaults();
    send_sample(16'd1000);
    send_sample(16'd1020);
    send_sample(16'd1010);
    send_sample(16'd1021);
    send_sample(16'd1021);
    send_sample(16'd999);
    send_sample(16'd0);
    send_sample(16'd65535);
    drain_results();
  endtask

  // Full-scale and zero limits, full-scale thresholds and the floor at zero.
  task automatic test_limit_extremes();
    configure(1'b0, 16'd1000, 16'd1020, '1, 1'b0);
    send_sample(16'd65535);
    send_sample(16'd65535);
    configure(1'b0, 16'd65535, 16'd65535, LIMIT_W'(1), 1'b0);
    send_sample(16'd65535);
    send_sample(16'd0);
    configure(1'b0, 16'd0, 16'd0, '0, 1'b0);
    send_sample(16'd0);
    send_sample(16'd1);
    send_sample(16'd65535);
  endtask

  // Linear mode with the upper threshold below nominal, and writes to
  // unknown register indexes that must change nothing.
  task automatic test_linear_mode();
    configure(1'b1, 16'd500, 16'd400, LIMIT_W'(2), 1'b1);
    send_sample(16'd450);
    send_sample(16'd300);
    send_sample(16'd0);
    send_sample(16'd65535);
    send_sample(16'd401);
    send_sample(16'd65535);
    send_sample(16'd400);
    drain_results();
  endtask

  // A long output stall while samples keep coming, then a full drain.
  task automatic test_output_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_span      = HOLD_CYCLES;
    hold_orders++;
    repeat (16) send_sample(pick_current(CUR_ABOVE));
    drain_results();
  endtask

  // Random bursts over several settings and handshake idling patterns.
  task automatic test_random_traffic();
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      apply_random_setting();
      case (seg % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 88;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 88;
        end
        default: begin
          src_idle_pct   = 22;
          sink_stall_pct = 22;
        end
      endcase
      run_traffic(SEGMENT_WORDS);
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  // Result side ready, with random stalls and ordered long holds.
  initial begin : result_ready_driver
    int unsigned hold_served;
    int unsigned hold_left;
    hold_served = 0;
    hold_left   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_orders) begin
        hold_served = hold_orders;
        hold_left   = hold_span;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin : result_check
    i2t_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no sample pending: accumulator_value %0d",
               out_ch.accumulator_value);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.accumulator_value !== want.accumulator_value) begin
          $error("accumulator_value: expected %0d, got %0d", want.accumulator_value,
                 out_ch.accumulator_value);
          fail_count++;
        end
        if (out_ch.overload !== want.overload) begin
          $error("overload: expected %0d, got %0d", want.overload, out_ch.overload);
          fail_count++;
        end
        if (out_ch.load_percent !== want.load_percent) begin
          $error("load_percent: expected %0d, got %0d", want.load_percent,
                 out_ch.load_percent);
          fail_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.load_current <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    mdl_linear  = RST_LINEAR_MODE;
    mdl_nominal = RST_NOMINAL_CURRENT;
    mdl_upper   = RST_UPPER_CURRENT;
    mdl_limit   = RST_ACCUMULATOR_LIMIT;
    mdl_acc     = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_limit_extremes();
    test_linear_mode();
    test_output_backpressure();
    test_random_traffic();
    drain_results();

    $display("Checked %0d samples in squared and linear mode across %0d register writes,",
             samples_sent, reg_writes);
    $display("with zero and full-scale limits, threshold edges and stalls on both channels.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
